### design/valid_dirty_shadow_cache_core_defines.svh
// Assertion macros for the valid/dirty shadow cache core.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef VALID_DIRTY_SHADOW_CACHE_CORE_DEFINES_SVH
`define VALID_DIRTY_SHADOW_CACHE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define VDSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define VDSC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define VDSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VDSC_ASSERT(lbl, clk, rst, prop, msg)
`define VDSC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define VDSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### design/vdsc_pkg.sv
// Shared types and constants for the valid/dirty shadow cache core.
// No dependencies; imported by valid_dirty_shadow_cache_core.
`timescale 1ns / 1ps

package vdsc_pkg;

   localparam int DATA_W  = 64;
   localparam int INDEX_W = 7;
   localparam int FIDX_W  = 6;

   // Operation codes carried in the request tuser.
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_INVAL = 2'd2;
   localparam logic [1:0] OP_FLUSH = 2'd3;

   // One result transaction as held in the output register.
   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              read_hit;
      logic [FIDX_W-1:0] flushed_index;
      logic              flushed_valid;
      logic              any_dirty;
      logic              last;
   } rsp_type;

endpackage

### design/valid_dirty_shadow_cache_core.sv
// Valid/dirty shadow cache core: value memory, valid and dirty marks, and control.
// Depends on vdsc_pkg and valid_dirty_shadow_cache_core_defines.svh.
`timescale 1ns / 1ps
`include "valid_dirty_shadow_cache_core_defines.svh"

// Channel   Direction  Signals                      Contents
// req       in         req_tvalid/tready/tdata/tuser  one operation per transaction
// rsp       out        rsp_tvalid/tready/tdata/tuser/tlast  one or more results per operation
// csr       in         csr_we/csr_wdata             shadow_disable register
//
// In a single-entry operation the accept cycle launches the memory read, and the
// execution state then performs the read-modify-write and loads the output register.
// A notifying flush of all entries with any dirty mark set then walks the dirty marks, one
// entry per cycle except where a dirty entry waits for rsp_tready, until the highest dirty
// entry has been reported. Reset is synchronous and clears all valid and dirty marks at
// once; the value memory is not cleared. A stalled result transaction holds the output
// register, and the engine waits for it to drain before producing the next result.

module valid_dirty_shadow_cache_core
   import vdsc_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // [6:0] entry_index, [70:7] write_value, [71] zero
   input  logic [2:0]  req_tuser,  // [1:0] opcode, [2] notify
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // [63:0] read_data, [69:64] flushed_index,
                                   // [70] any_dirty, [71] zero
   output logic [1:0]  rsp_tuser,  // [0] read_hit, [1] flushed_valid
   output logic        rsp_tlast,
   // Configuration port.
   input  logic        csr_we,
   input  logic        csr_wdata
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [DATA_W-1:0]  value_ff, value_in;
   logic               notify_ff, notify_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] dirty_ff, dirty_in;
   logic               global_dirty_ff, global_dirty_in;
   logic               shadow_disable_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // Value memory with a registered read port.
   logic [DATA_W-1:0]  value_mem [ENTRIES];
   logic [DATA_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               mem_we;

   logic               req_fire;
   logic               out_free;
   logic               in_range;
   logic [IDX_W-1:0]   ent;
   logic [ENTRIES-1:0] ent_bit;
   logic               same_value;
   logic [ENTRIES-1:0] low_mask;
   logic               scan_last;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign in_range   = idx_ff < INDEX_W'(ENTRIES);
   assign ent        = idx_ff[IDX_W-1:0];
   assign ent_bit    = ENTRIES'(1) << ent;
   assign same_value = valid_ff[ent] && (rd_data_ff == value_ff);

   // Entries at or below the scan position; anything dirty above it means more results.
   assign low_mask   = {ENTRIES{1'b1}} >> (IDX_W'(ENTRIES - 1) - scan_ff);
   assign scan_last  = ~|(dirty_ff & ~low_mask);

   // The read address follows the incoming request at accept and then holds, so the
   // read data stays valid while the result waits for room in the output register.
   assign rd_addr = (state_ff == ST_IDLE) ? req_tdata[IDX_W-1:0] : ent;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         value_mem[ent] <= value_ff;
      end
      rd_data_ff <= value_mem[rd_addr];
   end

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      idx_in          = idx_ff;
      value_in        = value_ff;
      notify_in       = notify_ff;
      scan_in         = scan_ff;
      valid_in        = valid_ff;
      dirty_in        = dirty_ff;
      global_dirty_in = global_dirty_ff;
      mem_we          = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_in          = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_tuser[1:0];
               notify_in = req_tuser[2];
               idx_in    = req_tdata[INDEX_W-1:0];
               value_in  = req_tdata[INDEX_W +: DATA_W];
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_in       = '0;
               rsp_in.last  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               case (op_ff)
                  OP_WRITE: begin
                     if (!shadow_disable_ff && in_range && !same_value) begin
                        mem_we          = 1'b1;
                        valid_in        = valid_ff | ent_bit;
                        dirty_in        = dirty_ff | ent_bit;
                        global_dirty_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (!shadow_disable_ff && in_range && valid_ff[ent]) begin
                        rsp_in.read_data = rd_data_ff;
                        rsp_in.read_hit  = 1'b1;
                     end
                  end
                  OP_INVAL: begin
                     if (in_range) begin
                        valid_in = valid_ff & ~ent_bit;
                     end else begin
                        valid_in = '0;
                        dirty_in = '0;
                     end
                  end
                  OP_FLUSH: begin
                     if (in_range) begin
                        if (dirty_ff[ent]) begin
                           dirty_in = dirty_ff & ~ent_bit;
                           if (notify_ff) begin
                              rsp_in.flushed_index = idx_ff[FIDX_W-1:0];
                              rsp_in.flushed_valid = 1'b1;
                           end
                        end
                     end else begin
                        global_dirty_in = 1'b0;
                        if (!notify_ff) begin
                           dirty_in = '0;
                        end else if (|dirty_ff) begin
                           // Report every dirty entry; the first result comes from the walk.
                           rsp_valid_in = rsp_valid_ff && !rsp_tready;
                           rsp_in       = rsp_ff;
                           scan_in      = '0;
                           state_in     = ST_SCAN;
                        end
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
               if (state_in == ST_IDLE) begin
                  rsp_in.any_dirty = global_dirty_in;
               end
            end
         end
         ST_SCAN: begin
            if (dirty_ff[scan_ff]) begin
               if (out_free) begin
                  rsp_in               = '0;
                  rsp_in.flushed_index = FIDX_W'(scan_ff);
                  rsp_in.flushed_valid = 1'b1;
                  rsp_in.last          = scan_last;
                  rsp_valid_in         = 1'b1;
                  if (scan_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     scan_in = scan_ff + 1'b1;
                  end
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         valid_ff          <= '0;
         dirty_ff          <= '0;
         global_dirty_ff   <= 1'b0;
         shadow_disable_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff        <= state_in;
         valid_ff        <= valid_in;
         dirty_ff        <= dirty_in;
         global_dirty_ff <= global_dirty_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_we) begin
            shadow_disable_ff <= csr_wdata;
         end
      end
   end

   // Transaction context and result payload need no reset.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      value_ff  <= value_in;
      notify_ff <= notify_in;
      scan_ff   <= scan_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.any_dirty, rsp_ff.flushed_index, rsp_ff.read_data};
   assign rsp_tuser  = {rsp_ff.flushed_valid, rsp_ff.read_hit};
   assign rsp_tlast  = rsp_ff.last;

   `VDSC_ASSERT_NEXT(a_accept_exec, clock, reset, req_fire, state_ff == ST_EXEC, "accepted transaction did not move to execution")
   `VDSC_ASSERT_IMPL(a_scan_clean, clock, reset, state_ff == ST_SCAN, !global_dirty_ff, "global dirty flag set during dirty walk")
   `VDSC_ASSERT_IMPL(a_mid_result, clock, reset, rsp_valid_ff && !rsp_ff.last, rsp_ff.flushed_valid, "non-final result without a flushed entry")
   `VDSC_ASSERT_IMPL(a_hit_enabled, clock, reset, rsp_valid_ff && rsp_ff.read_hit, !shadow_disable_ff, "read hit reported while disabled")

endmodule
